### rtl/smx_pkg.sv
`default_nettype none
package smx_pkg;
   localparam int StoreDepth = 64;
   localparam int ValueW = 16;
   localparam int ExpW = 17;
   localparam int SumW = 23;
   localparam int PosW = 6;
   localparam int CntW = 7;
   localparam logic [11:0] ClampLow = 12'd2560;
   localparam logic [16:0] COne = 17'd65536;
   localparam logic [16:0] CHalf = 17'd32768;
   localparam logic [16:0] CSixth = 17'd10918;
   localparam logic [16:0] C24th = 17'd2733;
   localparam logic [16:0] CInvE = 17'd24109;

   typedef struct packed {
      logic signed [15:0] value;
      logic last;
   } req_type;

   typedef struct packed {
      logic [16:0] prob;
      logic [5:0] position;
      logic final_res;
      logic dropped;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD, ST_EXP_RD, ST_EXP_RUN, ST_DIV_RD, ST_DIV_RUN, ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      EU_IDLE, EU_POLY, EU_SCALE, EU_DONE
   } exp_state_type;
endpackage
`default_nettype wire

### rtl/smx_exp.sv
`default_nettype none
// exp(d) for d <= 0: four horner steps, then one 1/e multiply per integer unit
module smx_exp (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic signed [16:0] diff,
   output logic done,
   output logic [16:0] result
);
   smx_pkg::exp_state_type state_ff, state_in;
   logic [16:0] e_ff, e_in;
   logic [7:0] g_ff, g_in;
   logic [3:0] n_ff, n_in;
   logic [1:0] step_ff, step_in;
   logic [16:0] a;
   logic [16:0] coef;
   logic [24:0] fprod;
   logic [16:0] fmul;
   logic [33:0] sprod;

   always_comb begin
      if (diff < -$signed({5'd0, smx_pkg::ClampLow})) a = {5'd0, smx_pkg::ClampLow};
      else if (diff > 0) a = '0;
      else a = 17'(-diff);
   end

   always_comb begin
      unique case (step_ff)
         2'd0: coef = smx_pkg::CSixth;
         2'd1: coef = smx_pkg::CHalf;
         default: coef = smx_pkg::COne;
      endcase
      fprod = 25'(e_ff) * 25'(g_ff) + 25'd128;
      fmul = fprod[24:8];
      sprod = 34'(e_ff) * 34'(smx_pkg::CInvE) + 34'd32768;
   end

   always_comb begin
      state_in = state_ff;
      e_in = e_ff;
      g_in = g_ff;
      n_in = n_ff;
      step_in = step_ff;
      unique case (state_ff)
         smx_pkg::EU_IDLE, smx_pkg::EU_DONE: begin
            if (start) begin
               e_in = smx_pkg::C24th;
               g_in = a[7:0];
               n_in = a[11:8];
               step_in = '0;
               state_in = smx_pkg::EU_POLY;
            end else state_in = smx_pkg::EU_IDLE;
         end
         smx_pkg::EU_POLY: begin
            e_in = coef - fmul;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) state_in = smx_pkg::EU_SCALE;
         end
         smx_pkg::EU_SCALE: begin
            if (n_ff == '0) state_in = smx_pkg::EU_DONE;
            else begin
               e_in = sprod[32:16];
               n_in = n_ff - 4'd1;
            end
         end
         default: state_in = smx_pkg::EU_IDLE;
      endcase
   end

   assign done = (state_ff == smx_pkg::EU_DONE);
   assign result = e_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= smx_pkg::EU_IDLE;
      else state_ff <= state_in;
      e_ff <= e_in;
      g_ff <= g_in;
      n_ff <= n_in;
      step_ff <= step_in;
   end
endmodule
`default_nettype wire

### rtl/smx_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle, rounded to nearest
module smx_div (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [16:0] num,
   input wire logic [22:0] den,
   output logic done,
   output logic [16:0] quot
);
   localparam int NumW = 34;
   logic [NumW-1:0] n_ff, n_in;
   logic [23:0] r_ff, r_in;
   logic [NumW-1:0] q_ff, q_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [23:0] rs;

   always_comb begin
      n_in = n_ff;
      r_in = r_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rs = {r_ff[22:0], n_ff[NumW-1]};
      if (start) begin
         n_in = {num, 16'd0} + NumW'(den >> 1);
         r_in = '0;
         q_in = '0;
         cnt_in = 6'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = n_ff << 1;
         if (rs >= {1'b0, den}) begin
            r_in = rs - {1'b0, den};
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            r_in = rs;
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff[16:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff <= n_in;
      r_ff <= r_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
   end
endmodule
`default_nettype wire

### rtl/softmax_vector_engine_core.sv
`default_nettype none
// softmax vector engine
// req channel: one signed q8.8 element per transfer, req.last closes the vector
// rsp channel: one transfer per stored element, in input order, carrying the
// q1.16 probability, its position, final_res on the last one and dropped if
// elements beyond VECTOR_LEN were discarded in that vector
// loading takes one cycle per element, the running maximum is updated on entry
// after the last element the element memory is read again, one element at a
// time; exp runs four horner steps plus one 1/e multiply per integer unit of
// the difference, and the results go to the exp memory
// then each exponential is read back and divided by the sum in a bit-serial
// divider; each result is taken on rsp before the next exponential is read
// req_ready is low from the last element until the final result is taken
// a stalled rsp holds the result in the output register and the engine waits
// reset clears count, maximum, sum and overflow flag; memories need no clearing
module softmax_vector_engine_core #(
   parameter int VECTOR_LEN = smx_pkg::StoreDepth
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire smx_pkg::req_type req,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output smx_pkg::rsp_type rsp
);
   localparam int AddrW = $clog2(smx_pkg::StoreDepth);

   // element and exponential memories
   logic signed [15:0] elem_mem [smx_pkg::StoreDepth];
   logic [16:0] exp_mem [smx_pkg::StoreDepth];
   logic signed [15:0] elem_rd_ff;
   logic [16:0] exp_rd_ff;

   smx_pkg::state_type state_ff, state_in;
   logic [6:0] count_ff, count_in;
   logic [6:0] idx_ff, idx_in;
   logic signed [15:0] max_ff, max_in;
   logic [22:0] sum_ff, sum_in;
   logic ovf_ff, ovf_in;
   smx_pkg::rsp_type rsp_ff, rsp_in;

   logic accept, stored;
   logic elem_we, exp_we;
   logic [AddrW-1:0] rd_addr;
   logic exp_start, exp_done, div_start, div_done;
   logic [16:0] exp_res, quot;
   logic exp_start_d;
   logic div_go_ff;

   assign accept = req_valid && req_ready;
   assign stored = accept && (count_ff < 7'(VECTOR_LEN));
   assign req_ready = (state_ff == smx_pkg::ST_LOAD);
   assign rsp_valid = (state_ff == smx_pkg::ST_OUT);
   assign rsp = rsp_ff;
   assign rd_addr = idx_ff[AddrW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smx_pkg::ST_LOAD:
            if (accept && req.last) state_in = smx_pkg::ST_EXP_RD;
         smx_pkg::ST_EXP_RD: state_in = smx_pkg::ST_EXP_RUN;
         smx_pkg::ST_EXP_RUN:
            if (exp_done) state_in = (idx_ff + 7'd1 == count_ff)
               ? smx_pkg::ST_DIV_RD : smx_pkg::ST_EXP_RD;
         smx_pkg::ST_DIV_RD: state_in = smx_pkg::ST_DIV_RUN;
         smx_pkg::ST_DIV_RUN: if (div_done) state_in = smx_pkg::ST_OUT;
         smx_pkg::ST_OUT:
            if (rsp_ready) state_in = rsp_ff.final_res
               ? smx_pkg::ST_LOAD : smx_pkg::ST_DIV_RD;
         default: state_in = smx_pkg::ST_LOAD;
      endcase
   end

   // datapath control
   always_comb begin
      count_in = count_ff;
      idx_in = idx_ff;
      max_in = max_ff;
      sum_in = sum_ff;
      ovf_in = ovf_ff;
      rsp_in = rsp_ff;
      elem_we = 1'b0;
      exp_we = 1'b0;
      exp_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         smx_pkg::ST_LOAD: begin
            if (stored) begin
               elem_we = 1'b1;
               count_in = count_ff + 7'd1;
               if (req.value > max_ff) max_in = req.value;
            end else if (accept) ovf_in = 1'b1;
            if (accept && req.last) begin
               idx_in = '0;
               sum_in = '0;
            end
         end
         smx_pkg::ST_EXP_RD: exp_start = 1'b1;
         smx_pkg::ST_EXP_RUN: begin
            if (exp_done) begin
               exp_we = 1'b1;
               sum_in = sum_ff + 23'(exp_res);
               idx_in = (idx_ff + 7'd1 == count_ff) ? 7'd0 : idx_ff + 7'd1;
            end
         end
         smx_pkg::ST_DIV_RD: div_start = 1'b1;
         smx_pkg::ST_DIV_RUN: begin
            if (div_done) begin
               rsp_in.prob = quot;
               rsp_in.position = idx_ff[5:0];
               rsp_in.final_res = (idx_ff + 7'd1 == count_ff);
               rsp_in.dropped = ovf_ff;
            end
         end
         smx_pkg::ST_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 7'd1;
               if (rsp_ff.final_res) begin
                  count_in = '0;
                  max_in = 16'sh8000;
                  sum_in = '0;
                  ovf_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   // divider starts once the exp memory read is registered
   always_ff @(posedge clock) begin
      if (reset) div_go_ff <= 1'b0;
      else div_go_ff <= div_start;
   end

   // memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (elem_we) elem_mem[count_ff[AddrW-1:0]] <= req.value;
      elem_rd_ff <= elem_mem[rd_addr];
      if (exp_we) exp_mem[rd_addr] <= exp_res;
      exp_rd_ff <= exp_mem[rd_addr];
   end

   // exp starts once the element read is registered
   always_ff @(posedge clock) begin
      if (reset) exp_start_d <= 1'b0;
      else exp_start_d <= exp_start;
   end

   smx_exp u_exp (
      .clock(clock), .reset(reset), .start(exp_start_d),
      .diff(17'(elem_rd_ff) - 17'(max_ff)),
      .done(exp_done), .result(exp_res)
   );

   smx_div u_div (
      .clock(clock), .reset(reset), .start(div_go_ff),
      .num(exp_rd_ff), .den(sum_ff), .done(div_done), .quot(quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smx_pkg::ST_LOAD;
         count_ff <= '0;
         idx_ff <= '0;
         max_ff <= 16'sh8000;
         sum_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff <= idx_in;
         max_ff <= max_in;
         sum_ff <= sum_in;
         ovf_ff <= ovf_in;
      end
      rsp_ff <= rsp_in;
   end

   // no new element while results of a vector are pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("req ready during output");
   // count never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= 7'(VECTOR_LEN)) else $error("count above capacity");
   // after the final result the vector state is cleared
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp.final_res |=> count_ff == '0 && !ovf_ff)
      else $error("vector state not cleared");
endmodule
`default_nettype wire

### tb/sv/softmax_checker.sv
`default_nettype none
module softmax_checker #(
   parameter int VECTOR_LEN = smx_pkg::StoreDepth
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire smx_pkg::req_type req,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire smx_pkg::rsp_type rsp,
   output int errors,
   output int pending
);
   logic signed [15:0] kept_values [smx_pkg::StoreDepth];
   logic [16:0] kept_exps [smx_pkg::StoreDepth];
   int kept_count;
   int vector_max;
   logic lost_any;
   smx_pkg::rsp_type prob_queue [$];

   // exp(d) in q1.16, d in q8.8 and never positive
   function automatic logic [16:0] exp_fixed(input int d);
      int a;
      int n;
      int unsigned g;
      int unsigned e;
      if (d < -2560) d = -2560;
      if (d > 0) d = 0;
      a = -d;
      n = a >> 8;
      g = a & 255;
      e = 2733;
      e = 10918 - ((e * g + 128) >> 8);
      e = 32768 - ((e * g + 128) >> 8);
      e = 65536 - ((e * g + 128) >> 8);
      e = 65536 - ((e * g + 128) >> 8);
      for (int k = 0; k < n; k++) begin
         e = int'((longint'(e) * 24109 + 32768) >> 16);
      end
      return e[16:0];
   endfunction

   always @(posedge clock) begin
      longint total;
      longint p;
      smx_pkg::rsp_type r;
      smx_pkg::rsp_type want;
      if (reset) begin
         kept_count = 0;
         vector_max = -32768;
         lost_any = 1'b0;
         prob_queue.delete();
         errors = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (prob_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected rsp transfer %p", $time, rsp);
            end else begin
               want = prob_queue.pop_front();
               if (rsp.prob !== want.prob) begin
                  errors++;
                  $display("%0t: prob expected %0d actual %0d", $time, want.prob, rsp.prob);
               end
               if (rsp.position !== want.position) begin
                  errors++;
                  $display("%0t: position expected %0d actual %0d", $time,
                           want.position, rsp.position);
               end
               if (rsp.final_res !== want.final_res) begin
                  errors++;
                  $display("%0t: final_res expected %0d actual %0d", $time,
                           want.final_res, rsp.final_res);
               end
               if (rsp.dropped !== want.dropped) begin
                  errors++;
                  $display("%0t: dropped expected %0d actual %0d", $time,
                           want.dropped, rsp.dropped);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (kept_count < VECTOR_LEN) begin
               kept_values[kept_count] = req.value;
               kept_count++;
               if (int'(req.value) > vector_max) vector_max = req.value;
            end else begin
               lost_any = 1'b1;
            end
            if (req.last) begin
               total = 0;
               for (int k = 0; k < kept_count; k++) begin
                  kept_exps[k] = exp_fixed(int'(kept_values[k]) - vector_max);
                  total = (total + kept_exps[k]) & 23'h7fffff;
               end
               for (int k = 0; k < kept_count; k++) begin
                  p = 0;
                  if (total != 0) p = ((longint'(kept_exps[k]) << 16) + (total >> 1)) / total;
                  r.prob = p[16:0];
                  r.position = k[5:0];
                  r.final_res = (k + 1 == kept_count);
                  r.dropped = lost_any;
                  prob_queue.push_back(r);
               end
               kept_count = 0;
               vector_max = -32768;
               lost_any = 1'b0;
            end
         end
      end
      pending = prob_queue.size();
   end
endmodule
`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none
module testbench;
   localparam int CycleLimit = 1000000;
   localparam int ItemTarget = 320;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   smx_pkg::req_type req;
   logic rsp_valid;
   logic rsp_ready;
   smx_pkg::rsp_type rsp;
   int errors;
   int pending;

   // stimulus-side knobs and counters; quiet and hold_request are shared with the receiver
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int items_sent = 0;
   int cycles = 0;

   always #5 clock = ~clock;

   softmax_vector_engine_core u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req(req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp(rsp)
   );

   softmax_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req(req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp(rsp),
      .errors(errors),
      .pending(pending)
   );

   // watchdog on the whole run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("** softmax_vector_engine_core: FAILED **");
         $finish;
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   always @(posedge clock) begin
      int stall_left;
      int hold_left;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 900;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one element transfer, with an optional idle burst in front of it
   task automatic send_element(input logic signed [15:0] v, input logic is_last);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req.value <= v;
      req.last <= is_last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // element value drawn from a few flavours: tight spread, full range, edges
   function automatic logic signed [15:0] pick_value(input int centre);
      int pick;
      int v;
      pick = $urandom_range(0, 9);
      if (pick < 5) v = centre + $urandom_range(0, 3200) - 1600;
      else if (pick < 8) v = $urandom_range(0, 65535) - 32768;
      else case ($urandom_range(0, 3))
         0: v = -32768;
         1: v = 32767;
         2: v = centre;
         default: v = centre - 2560;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   task automatic send_vector(input int len);
      int centre;
      centre = $urandom_range(0, 8000) - 4000;
      for (int k = 0; k < len; k++) begin
         send_element(pick_value(centre), k == len - 1);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      int len;
      int vectors;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single elements at the extremes
      send_element(16'sd0, 1'b1);
      send_element(-16'sd32768, 1'b1);
      send_element(16'sd32767, 1'b1);
      // full-range spread, the small one is clamped at -10.0
      send_element(16'sd32767, 1'b0);
      send_element(-16'sd32768, 1'b1);
      // fractions, whole units and the clamp boundary either side
      send_element(16'sd0, 1'b0);
      send_element(-16'sd128, 1'b0);
      send_element(-16'sd256, 1'b0);
      send_element(-16'sd255, 1'b0);
      send_element(-16'sd2560, 1'b0);
      send_element(-16'sd2561, 1'b0);
      send_element(-16'sd2559, 1'b1);
      // equal elements
      send_element(16'sd100, 1'b0);
      send_element(16'sd100, 1'b0);
      send_element(16'sd100, 1'b1);
      // maximum arriving late
      send_element(-16'sd1000, 1'b0);
      send_element(-16'sd500, 1'b0);
      send_element(16'sd700, 1'b1);
      wait_drained();

      // random vectors, mostly short; a few full and over-full ones
      vectors = 0;
      while (items_sent < ItemTarget) begin
         vectors++;
         case ($urandom_range(0, 29))
            0: len = 64;
            1: len = $urandom_range(65, 70);
            default: len = $urandom_range(1, 10);
         endcase
         if (vectors == 3) len = 64;
         if (vectors == 5) len = 66;
         // long receiver hold-off while the sender keeps offering
         if (vectors == 8) hold_request = 1'b1;
         if (items_sent > ItemTarget - 40) quiet = 1'b1;
         send_vector(len);
         // sender stops until everything has come back
         if (vectors == 12) wait_drained();
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("** softmax_vector_engine_core: PASSED **");
      end else begin
         $display("** softmax_vector_engine_core: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire

### filelist.f
rtl/smx_pkg.sv
rtl/smx_exp.sv
rtl/smx_div.sv
rtl/softmax_vector_engine_core.sv
tb/sv/softmax_checker.sv
tb/sv/testbench.sv
